@@ hdl/sobel_pkg.sv @@
// Shared types and constants for the Sobel 3x3 gray edge filter.
`timescale 1ns / 1ps

package sobel_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int OFIFO_DEPTH   = 8;
	localparam int FW_W          = 12;
	localparam int FH_W          = 16;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	// register indexes on the configuration port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] edge_magnitude;
		logic       end_of_row;
		logic       end_of_frame;
	} mag_req_t;

	// 3x3 gray window, index row*3 + col, row 0 top, col 0 left
	typedef logic [8:0][7:0] win_t;

	typedef struct packed {
		logic end_of_row;
		logic end_of_frame;
	} pos_flags_t;

endpackage

@@ hdl/sobel3x3_gray_edge_filter.sv @@
// Top level of the Sobel 3x3 gray edge filter: line stores, window, control.
`timescale 1ns / 1ps

// Usage
//   pix channel: one RGB-style pixel request per cycle in raster order
//   (pix_valid / pix_stall). Each pixel turns into gray, floor(sum / 3).
//   mag channel: one request per interior pixel with |gx| + |gy| saturated
//   to 255, end_of_row on the last interior pixel of a row and
//   end_of_frame on the last one of the image. Border pixels give nothing.
//   APB port: register 0 frame_width at 0x0, register 1 frame_height at 0x4.
//   Write them only while no pixel is in flight; pready is tied high.
// Throughput and pipeline
//   One pixel per cycle sustained while pix_stall is low. A result passes
//   through these registered steps before it shows on the mag port:
//   line store read, window shift with write-back, gradient register,
//   queue write.
//   The two line stores are 1R1W memories read at accept and written
//   in the cycle after; the same column comes back no sooner than three
//   pixels later, so no forwarding is needed.
// Reset and stall
//   Reset clears the counters, the window, the queue and the registers
//   (640 x 480). Line stores are not cleared: the first two rows only
//   fill them and emit nothing. When the receiver stalls, results collect
//   in an eight-entry queue; pix_stall rises once queue plus in-flight
//   results reach eight, and the mag request holds steady while stalled.

module sobel3x3_gray_edge_filter #(
	parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  sobel_pkg::pix_req_t pix,
	output logic                mag_valid,
	input  logic                mag_stall,
	output sobel_pkg::mag_req_t mag,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import sobel_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
	localparam int QW = $clog2(OFIFO_DEPTH + 1);
	// floor(x / 3) for x <= 765 as (x * 683) >> 11
	localparam logic [10:0] GRAY_RECIP = 11'd683;
	localparam int          GRAY_SHIFT = 11;

	// configuration registers
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	// position of the next pixel
	logic [CW-1:0]   col_q;
	logic [FH_W-1:0] row_q;

	// accept stage
	logic            pix_acc;
	logic [9:0]      ch_sum;
	logic [20:0]     gray_prod;
	logic [EW-1:0]   fw_ext, w_eff;
	logic [FH_W-1:0] h_eff;
	logic            last_col, last_row, emit;

	// stage 1: line store data returns
	logic            a_s1, v_s1;
	logic [CW-1:0]   idx_s1;
	logic [7:0]      gray_s1;
	pos_flags_t      flags_s1;
	logic [7:0]      rd_prev_s1, rd_prev2_s1;

	// stage 2: window
	win_t            win_q;
	logic            v_s2;
	pos_flags_t      flags_s2;

	// line stores
	logic [7:0]      prev_mem  [MAX_WIDTH];
	logic [7:0]      prev2_mem [MAX_WIDTH];

	// gradient and output queue
	logic            res_valid;
	mag_req_t        res;
	logic [QW-1:0]   q_count;
	logic [QW+1:0]   occupancy;

	// -------- configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {{(32-FW_W){1'b0}}, frame_width_q};
			REG_FRAME_HEIGHT: prdata = {{(32-FH_W){1'b0}}, frame_height_q};
			default:          prdata = '0;
		endcase
	end

	// -------- accept: credit against queue plus in-flight results
	assign occupancy = (QW+2)'(q_count) + (QW+2)'(v_s1) + (QW+2)'(v_s2)
		+ (QW+2)'(res_valid);
	assign pix_stall = (occupancy >= (QW+2)'(OFIFO_DEPTH));
	assign pix_acc   = pix_valid && !pix_stall;

	assign ch_sum    = 10'(pix.chan_a) + 10'(pix.chan_b) + 10'(pix.chan_c);
	assign gray_prod = 21'(ch_sum) * 21'(GRAY_RECIP);

	// clamp width to 3..MAX_WIDTH and height to at least 3
	always_comb begin
		fw_ext = EW'(frame_width_q);
		if (fw_ext < EW'(3)) begin
			w_eff = EW'(3);
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		h_eff = (frame_height_q < FH_W'(3)) ? FH_W'(3) : frame_height_q;
	end

	assign last_col = (EW'(col_q) >= w_eff - EW'(1));
	assign last_row = (row_q >= h_eff - FH_W'(1));
	assign emit     = (row_q >= FH_W'(2)) && (col_q >= CW'(2));

	// advance the raster position; wrap at or beyond the last column / row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// -------- stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1 <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			a_s1 <= pix_acc;
			v_s1 <= pix_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			idx_s1                <= col_q;
			gray_s1               <= gray_prod[GRAY_SHIFT +: 8];
			flags_s1.end_of_row   <= last_col;
			flags_s1.end_of_frame <= last_col && last_row;
		end
	end

	// line stores: read at accept, write back the shifted column in the next cycle
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			rd_prev_s1  <= prev_mem[col_q];
			rd_prev2_s1 <= prev2_mem[col_q];
		end
		if (a_s1) begin
			prev_mem[idx_s1]  <= gray_s1;
			prev2_mem[idx_s1] <= rd_prev_s1;
		end
	end

	// -------- stage 2: shift the window one column left, new column on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			if (a_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3+0] <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= rd_prev2_s1;
				win_q[5] <= rd_prev_s1;
				win_q[8] <= gray_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			flags_s2 <= flags_s1;
		end
	end

	// -------- gradient and output queue
	sobel_grad u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (v_s2),
		.win       (win_q),
		.win_flags (flags_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	sobel_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_req  (res),
		.mag_valid (mag_valid),
		.mag_stall (mag_stall),
		.mag       (mag),
		.count     (q_count)
	);

	// -------- assertions
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (QW+2)'(OFIFO_DEPTH))
		else $error("output queue credit overrun");

	a_emit_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> a_s1)
		else $error("result in flight without an accepted pixel");

	a_no_same_column: assert property (@(posedge clk) disable iff (!arst_n)
		(a_s1 && pix_acc) |-> (col_q != idx_s1))
		else $error("line store read overlaps pending write-back");

	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> a_s1)
		else $error("accepted pixel lost before line store stage");

	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(mag_valid && mag.end_of_frame) |-> mag.end_of_row)
		else $error("end of frame without end of row");

endmodule

@@ hdl/sobel_grad.sv @@
// Sobel X/Y gradient stage and saturated magnitude of the 3x3 window.
`timescale 1ns / 1ps

module sobel_grad (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 win_valid,
	input  sobel_pkg::win_t      win,
	input  sobel_pkg::pos_flags_t win_flags,
	output logic                 res_valid,
	output sobel_pkg::mag_req_t  res
);
	import sobel_pkg::*;

	logic signed [10:0] gx, gy;
	logic signed [10:0] gx_s3, gy_s3;
	pos_flags_t         flags_s3;
	logic        [10:0] abs_x, abs_y;
	logic        [11:0] mag_sum;

	function automatic logic signed [10:0] px(input logic [7:0] p);
		px = signed'({3'b000, p});
	endfunction

	assign gx = (px(win[2]) - px(win[0])) + ((px(win[5]) - px(win[3])) <<< 1)
		+ (px(win[8]) - px(win[6]));
	assign gy = (px(win[6]) - px(win[0])) + ((px(win[7]) - px(win[1])) <<< 1)
		+ (px(win[8]) - px(win[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win_valid) begin
			gx_s3    <= gx;
			gy_s3    <= gy;
			flags_s3 <= win_flags;
		end
	end

	assign abs_x   = gx_s3[10] ? 11'(-gx_s3) : 11'(gx_s3);
	assign abs_y   = gy_s3[10] ? 11'(-gy_s3) : 11'(gy_s3);
	assign mag_sum = {1'b0, abs_x} + {1'b0, abs_y};

	always_comb begin
		res.edge_magnitude = (mag_sum > 12'd255) ? 8'hFF : mag_sum[7:0];
		res.end_of_row     = flags_s3.end_of_row;
		res.end_of_frame   = flags_s3.end_of_frame;
	end

endmodule

@@ hdl/sobel_ofifo.sv @@
// Output request queue that decouples the filter pipeline from the receiver.
`timescale 1ns / 1ps

module sobel_ofifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sobel_pkg::mag_req_t push_req,
	output logic                mag_valid,
	input  logic                mag_stall,
	output sobel_pkg::mag_req_t mag,
	output logic [$clog2(sobel_pkg::OFIFO_DEPTH+1)-1:0] count
);
	import sobel_pkg::*;

	localparam int PW = $clog2(OFIFO_DEPTH);
	localparam int CW = $clog2(OFIFO_DEPTH + 1);

	mag_req_t        slot_q [OFIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic            pop;

	assign mag_valid = (count != '0);
	assign mag       = slot_q[rd_ptr_q];
	assign pop       = mag_valid && !mag_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OFIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OFIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count <= count + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

endmodule
